>>> design/fsam_pkg.sv
// ----------------------------------------------------------------------------
// fsam_pkg
// Shared types and constants for the fraction sum and maximum block.
// ----------------------------------------------------------------------------
package fsam_pkg;

	// sequencer steps, one arithmetic operation each apart from idle, check and finish
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GCD_ITEM,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_CHECK,
		ST_MUL_CUR,
		ST_MUL_BEST,
		ST_GCD_SUM,
		ST_DIV_ACC,
		ST_DIV_ITEM,
		ST_MUL_T1,
		ST_MUL_T2,
		ST_COMBINE,
		ST_DIV_REM,
		ST_GCD_RED,
		ST_DIV_Q,
		ST_DIV_DFAC,
		ST_MUL_DEN,
		ST_FINISH
	} state_t;

	// status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO_DEN = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] MAG_2P31 = 32'h8000_0000;
	localparam int unsigned DIV_STEPS = 128;

endpackage

>>> design/fraction_sum_and_max.sv
// ----------------------------------------------------------------------------
// fraction_sum_and_max
// Exact rational running sum and maximum over a stream of signed fractions.
// ----------------------------------------------------------------------------
// Sequence: a zero denominator goes straight to the finish step; other items use
// up to seven passes of the 128-step divider and three passes of the binary GCD
// (fewer for a rejected item or a zero sum); a held result adds its stall.
// Throughput: one transaction at a time; in_stall is high until it completes.
// Reset: asynchronous, active low; clears the sum to 0/1, the maximum to 0/1,
// the status and all handshake state.
module fraction_sum_and_max (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] numerator,
	input  logic signed [31:0] denominator,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] sum_numerator,
	output logic        [62:0] sum_denominator,
	output logic signed [31:0] max_numerator,
	output logic        [30:0] max_denominator,
	output logic        [1:0]  status
);
	import fsam_pkg::*;

	state_t state_q, state_d;
	logic   started_q, op_go, unit_done;
	logic   gcd_go, div_go, mul_go;
	logic [63:0]  gcd_a, gcd_b, div_den, mul_x, mul_y;
	logic [127:0] div_num;

	// accumulator state
	logic [63:0] acc_num_q, acc_den_q;
	logic [31:0] best_num_q, best_den_q;
	logic        have_best_q;
	logic [1:0]  err_q;

	// per transaction working registers
	logic        nneg_q, dneg_q, last_q, tneg_q;
	logic [31:0] nmag_q, dmag_q, nr_q, dr_q, drg_q, dfac_q;
	logic [63:0] gg_q, g2_q, adg_q, p1_q;
	logic [127:0] t1_q, mag_q, q_q;

	// output register
	logic        out_valid_q;
	logic [63:0] o_sum_num_q;
	logic [62:0] o_sum_den_q;
	logic [31:0] o_max_num_q;
	logic [30:0] o_max_den_q;
	logic [1:0]  o_status_q;

	// ---------------------------------------------------------------- gcd unit
	logic [63:0] ga_q, gb_q, gcd_res;
	logic [5:0]  gk_q;
	logic        gbusy_q, gdone_q;

	assign gcd_res = (ga_q | gb_q) << gk_q;

	// binary gcd, one shift or subtract per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbusy_q <= 1'b0;
			gdone_q <= 1'b0;
		end else begin
			gdone_q <= 1'b0;
			if (gcd_go) begin
				gbusy_q <= 1'b1;
			end else if (gbusy_q && (ga_q == 64'd0 || gb_q == 64'd0)) begin
				gbusy_q <= 1'b0;
				gdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gcd_go) begin
			ga_q <= gcd_a;
			gb_q <= gcd_b;
			gk_q <= '0;
		end else if (gbusy_q && ga_q != 64'd0 && gb_q != 64'd0) begin
			if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				gk_q <= gk_q + 6'd1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q >= gb_q) begin
				ga_q <= (ga_q - gb_q) >> 1;
			end else begin
				gb_q <= (gb_q - ga_q) >> 1;
			end
		end
	end

	// ------------------------------------------------------------ divider unit
	logic [127:0] dq_q;
	logic [63:0]  drm_q, dd_q;
	logic [6:0]   dcnt_q;
	logic         dbusy_q, ddone_q, dfits;
	logic [64:0]  dtrial, ddiff;

	assign dtrial = {drm_q, dq_q[127]};
	assign dfits  = dtrial >= {1'b0, dd_q};
	assign ddiff  = dtrial - {1'b0, dd_q};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (div_go) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 7'd1;
				if (dcnt_q == 7'(DIV_STEPS - 1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			dq_q  <= div_num;
			drm_q <= '0;
			dd_q  <= div_den;
		end else if (dbusy_q) begin
			drm_q <= dfits ? ddiff[63:0] : dtrial[63:0];
			dq_q  <= {dq_q[126:0], dfits};
		end
	end

	// --------------------------------------------------------- multiplier unit
	logic [63:0]  mx_q, my_q, pp_s1, pp_c;
	logic [127:0] macc_q;
	logic [1:0]   psh_s1;
	logic [2:0]   mcnt_q;
	logic         mbusy_q, mdone_q, pv_s1;
	logic [31:0]  mx_part, my_part;

	assign mx_part = mcnt_q[0] ? mx_q[63:32] : mx_q[31:0];
	assign my_part = mcnt_q[1] ? my_q[63:32] : my_q[31:0];
	assign pp_c    = mx_part * my_part;

	// four 32x32 partial products, registered, then accumulated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			pv_s1   <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mul_go) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
				pv_s1   <= 1'b0;
			end else if (mbusy_q) begin
				pv_s1 <= (mcnt_q != 3'd4);
				if (mcnt_q != 3'd4) begin
					mcnt_q <= mcnt_q + 3'd1;
				end else begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mx_q   <= mul_x;
			my_q   <= mul_y;
			macc_q <= '0;
		end else if (mbusy_q) begin
			if (mcnt_q != 3'd4) begin
				pp_s1  <= pp_c;
				psh_s1 <= {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
			end
			if (pv_s1) begin
				macc_q <= macc_q + ({64'd0, pp_s1} << {psh_s1, 5'd0});
			end
		end
	end

	assign unit_done = gdone_q | ddone_q | mdone_q;

	// ------------------------------------------------------- derived values
	logic        sneg, item_bad, replace, t_zero, q_ovf, den_ovf;
	logic [31:0] bmag, cn;
	logic [63:0] amag, q_lim;
	logic signed [64:0] s1, s2;
	logic [127:0] t1s, t2s, tsum;

	assign sneg     = (nneg_q != dneg_q) && (nr_q != 32'd0);
	assign item_bad = (dr_q == MAG_2P31) || ((nr_q == MAG_2P31) && !sneg);
	assign cn       = sneg ? (~nr_q + 32'd1) : nr_q;
	assign bmag     = best_num_q[31] ? (~best_num_q + 32'd1) : best_num_q;
	assign amag     = acc_num_q[63] ? (~acc_num_q + 64'd1) : acc_num_q;
	assign s1       = sneg ? -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q});
	assign s2       = best_num_q[31] ? -$signed({1'b0, macc_q[63:0]})
	                                 : $signed({1'b0, macc_q[63:0]});
	assign replace  = !have_best_q || (s1 > s2);
	assign t1s      = acc_num_q[63] ? (~t1_q + 128'd1) : t1_q;
	assign t2s      = sneg ? (~macc_q + 128'd1) : macc_q;
	assign tsum     = t1s + t2s;
	assign t_zero   = (tsum == 128'd0);
	assign q_lim    = S64_MAX + {63'd0, tneg_q};
	assign q_ovf    = (q_q[127:64] != 64'd0) || (q_q[63:0] > q_lim);
	assign den_ovf  = (macc_q[127:64] != 64'd0) || macc_q[63];

	// ----------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op_go) begin
				started_q <= 1'b1;
			end else if (unit_done) begin
				started_q <= 1'b0;
			end
		end
	end

	// next state, unit starts and operand selection
	always_comb begin
		state_d = state_q;
		op_go   = 1'b0;
		gcd_go  = 1'b0;
		div_go  = 1'b0;
		mul_go  = 1'b0;
		gcd_a   = '0;
		gcd_b   = '0;
		div_num = '0;
		div_den = '0;
		mul_x   = '0;
		mul_y   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (denominator == 32'sd0) ? ST_FINISH : ST_GCD_ITEM;
				end
			end
			ST_CHECK: begin
				state_d = item_bad ? ST_FINISH : ST_MUL_CUR;
			end
			ST_COMBINE: begin
				state_d = t_zero ? ST_FINISH : ST_DIV_REM;
			end
			ST_FINISH: begin
				if (!last_q || !(out_valid_q && out_stall)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				op_go = !started_q;
				unique case (state_q)
					ST_GCD_ITEM: begin
						gcd_go = op_go;
						gcd_a  = {32'd0, nmag_q};
						gcd_b  = {32'd0, dmag_q};
						if (unit_done) state_d = ST_DIV_NUM;
					end
					ST_DIV_NUM: begin
						div_go  = op_go;
						div_num = {96'd0, nmag_q};
						div_den = gg_q;
						if (unit_done) state_d = ST_DIV_DEN;
					end
					ST_DIV_DEN: begin
						div_go  = op_go;
						div_num = {96'd0, dmag_q};
						div_den = gg_q;
						if (unit_done) state_d = ST_CHECK;
					end
					ST_MUL_CUR: begin
						mul_go = op_go;
						mul_x  = {32'd0, nr_q};
						mul_y  = {32'd0, best_den_q};
						if (unit_done) state_d = ST_MUL_BEST;
					end
					ST_MUL_BEST: begin
						mul_go = op_go;
						mul_x  = {32'd0, bmag};
						mul_y  = {32'd0, dr_q};
						if (unit_done) state_d = ST_GCD_SUM;
					end
					ST_GCD_SUM: begin
						gcd_go = op_go;
						gcd_a  = acc_den_q;
						gcd_b  = {32'd0, dr_q};
						if (unit_done) state_d = ST_DIV_ACC;
					end
					ST_DIV_ACC: begin
						div_go  = op_go;
						div_num = {64'd0, acc_den_q};
						div_den = gg_q;
						if (unit_done) state_d = ST_DIV_ITEM;
					end
					ST_DIV_ITEM: begin
						div_go  = op_go;
						div_num = {96'd0, dr_q};
						div_den = gg_q;
						if (unit_done) state_d = ST_MUL_T1;
					end
					ST_MUL_T1: begin
						mul_go = op_go;
						mul_x  = amag;
						mul_y  = {32'd0, drg_q};
						if (unit_done) state_d = ST_MUL_T2;
					end
					ST_MUL_T2: begin
						mul_go = op_go;
						mul_x  = {32'd0, nr_q};
						mul_y  = adg_q;
						if (unit_done) state_d = ST_COMBINE;
					end
					ST_DIV_REM: begin
						div_go  = op_go;
						div_num = mag_q;
						div_den = gg_q;
						if (unit_done) state_d = ST_GCD_RED;
					end
					ST_GCD_RED: begin
						gcd_go = op_go;
						gcd_a  = gg_q;
						gcd_b  = drm_q;
						if (unit_done) state_d = ST_DIV_Q;
					end
					ST_DIV_Q: begin
						div_go  = op_go;
						div_num = mag_q;
						div_den = g2_q;
						if (unit_done) state_d = ST_DIV_DFAC;
					end
					ST_DIV_DFAC: begin
						div_go  = op_go;
						div_num = {96'd0, dr_q};
						div_den = g2_q;
						if (unit_done) state_d = ST_MUL_DEN;
					end
					ST_MUL_DEN: begin
						mul_go = op_go;
						mul_x  = adg_q;
						mul_y  = {32'd0, dfac_q};
						if (unit_done) state_d = ST_FINISH;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		endcase
	end

	// ------------------------------------------------- accumulator and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q   <= '0;
			acc_den_q   <= 64'd1;
			best_num_q  <= '0;
			best_den_q  <= 32'd1;
			have_best_q <= 1'b0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			// result handshake
			if (state_q == ST_FINISH && last_q && !(out_valid_q && out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			priority case (state_q)
				ST_IDLE: begin
					if (in_valid && denominator == 32'sd0 && err_q == STAT_OK) begin
						err_q <= STAT_ZERO_DEN;
					end
				end
				ST_CHECK: begin
					if (item_bad && err_q == STAT_OK) err_q <= STAT_OVERFLOW;
				end
				ST_MUL_BEST: begin
					if (unit_done && replace) begin
						best_num_q  <= cn;
						best_den_q  <= dr_q;
						have_best_q <= 1'b1;
					end
				end
				ST_COMBINE: begin
					if (t_zero) begin
						acc_num_q <= '0;
						acc_den_q <= 64'd1;
					end
				end
				ST_MUL_DEN: begin
					if (unit_done) begin
						if (q_ovf || den_ovf) begin
							if (err_q == STAT_OK) err_q <= STAT_OVERFLOW;
						end else begin
							acc_num_q <= tneg_q ? (~q_q[63:0] + 64'd1) : q_q[63:0];
							acc_den_q <= macc_q[63:0];
						end
					end
				end
				ST_FINISH: begin
					// hand over the result and start a fresh list
					if (last_q && !(out_valid_q && out_stall)) begin
						acc_num_q   <= '0;
						acc_den_q   <= 64'd1;
						best_num_q  <= '0;
						best_den_q  <= 32'd1;
						have_best_q <= 1'b0;
						err_q       <= STAT_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------ working and output data
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			nneg_q <= numerator[31];
			dneg_q <= denominator[31];
			nmag_q <= numerator[31] ? (~numerator + 32'd1) : numerator;
			dmag_q <= denominator[31] ? (~denominator + 32'd1) : denominator;
			last_q <= last_item;
		end
		if (unit_done) begin
			priority case (state_q)
				ST_GCD_ITEM, ST_GCD_SUM: gg_q <= gcd_res;
				ST_GCD_RED:  g2_q   <= gcd_res;
				ST_DIV_NUM:  nr_q   <= dq_q[31:0];
				ST_DIV_DEN:  dr_q   <= dq_q[31:0];
				ST_DIV_ACC:  adg_q  <= dq_q[63:0];
				ST_DIV_ITEM: drg_q  <= dq_q[31:0];
				ST_DIV_Q:    q_q    <= dq_q;
				ST_DIV_DFAC: dfac_q <= dq_q[31:0];
				ST_MUL_CUR:  p1_q   <= macc_q[63:0];
				ST_MUL_T1:   t1_q   <= macc_q;
				default: begin
				end
			endcase
		end
		// magnitude and sign of the cross-multiplied sum
		if (state_q == ST_COMBINE) begin
			tneg_q <= tsum[127];
			mag_q  <= tsum[127] ? (~tsum + 128'd1) : tsum;
		end
		if (state_q == ST_FINISH && last_q && !(out_valid_q && out_stall)) begin
			o_sum_num_q <= acc_num_q;
			o_sum_den_q <= acc_den_q[62:0];
			o_max_num_q <= best_num_q;
			o_max_den_q <= best_den_q[30:0];
			o_status_q  <= err_q;
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign sum_numerator   = o_sum_num_q;
	assign sum_denominator = o_sum_den_q;
	assign max_numerator   = o_max_num_q;
	assign max_denominator = o_max_den_q;
	assign status          = o_status_q;

endmodule

>>> sim/fsam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsam_checker
// Watches both channels of the fraction sum and maximum block, keeps its own
// exact rational sum and maximum, and compares each result transaction.
// ----------------------------------------------------------------------------
module fsam_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] numerator,
	input  logic signed [31:0] denominator,
	input  logic               last_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [63:0] sum_numerator,
	input  logic        [62:0] sum_denominator,
	input  logic signed [31:0] max_numerator,
	input  logic        [30:0] max_denominator,
	input  logic        [1:0]  status,
	output int                 fail_count,
	output int                 pending
);
	import fsam_pkg::*;

	typedef struct packed {
		logic signed [63:0] sum_n;
		logic        [62:0] sum_d;
		logic signed [31:0] max_n;
		logic        [30:0] max_d;
		status_t            stat;
	} list_result_t;

	list_result_t result_q[$];

	// results predicted and results taken
	int n_expected;
	int n_seen;

	// running list state
	logic signed [63:0] run_n;
	logic        [63:0] run_d;
	logic signed [31:0] top_n;
	logic        [31:0] top_d;
	logic               top_seen;
	status_t            run_stat;

	function automatic logic [127:0] euclid(logic [127:0] a, logic [127:0] b);
		logic [127:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	task automatic clear_list();
		run_n = 0;
		run_d = 1;
		top_n = 0;
		top_d = 1;
		top_seen = 0;
		run_stat = STAT_OK;
	endtask

	task automatic flag(status_t s);
		if (run_stat == STAT_OK)
			run_stat = s;
	endtask

	// one fraction into the sum and maximum; exact 128-bit signed arithmetic
	task automatic fold_fraction(logic signed [31:0] n, logic signed [31:0] d);
		logic signed [127:0] nn, dd, g, cn, cd, tn, td, gs;
		nn = n;
		dd = d;
		if (dd == 0) begin
			flag(STAT_ZERO_DEN);
			return;
		end
		if (dd < 0) begin
			nn = -nn;
			dd = -dd;
		end
		g = euclid(nn < 0 ? -nn : nn, dd);
		cn = nn / g;
		cd = dd / g;
		if (cd > 128'sh7FFF_FFFF || cn > 128'sh7FFF_FFFF || cn < -128'sh8000_0000) begin
			flag(STAT_OVERFLOW);
			return;
		end
		if (!top_seen || cn * $signed({96'd0, top_d}) > $signed(top_n) * cd) begin
			top_n = cn[31:0];
			top_d = cd[31:0];
			top_seen = 1;
		end
		tn = $signed(run_n) * cd + cn * $signed({64'd0, run_d});
		td = $signed({64'd0, run_d}) * cd;
		if (tn == 0) begin
			run_n = 0;
			run_d = 1;
			return;
		end
		gs = euclid(tn < 0 ? -tn : tn, td);
		tn = tn / gs;
		td = td / gs;
		if (tn > 128'sh7FFF_FFFF_FFFF_FFFF || tn < -128'sh8000_0000_0000_0000 ||
		    td > 128'sh7FFF_FFFF_FFFF_FFFF) begin
			flag(STAT_OVERFLOW);
			return;
		end
		run_n = tn[63:0];
		run_d = td[63:0];
	endtask

	assign pending = n_expected - n_seen;

	// input transactions
	always @(posedge clk or negedge arst_n) begin
		list_result_t r;
		if (!arst_n) begin
			clear_list();
			result_q.delete();
			n_expected = 0;
		end else if (in_valid && !in_stall) begin
			fold_fraction(numerator, denominator);
			if (last_item) begin
				r.sum_n = run_n;
				r.sum_d = run_d[62:0];
				r.max_n = top_n;
				r.max_d = top_d[30:0];
				r.stat = run_stat;
				result_q.push_back(r);
				n_expected = n_expected + 1;
				clear_list();
			end
		end
	end

	// output transactions
	always @(posedge clk or negedge arst_n) begin
		list_result_t e;
		if (!arst_n) begin
			fail_count <= 0;
			n_seen <= 0;
		end else if (out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				fail_count <= fail_count + 1;
				if (fail_count < 10)
					$display("%0t: unexpected result transaction", $realtime);
			end else begin
				e = result_q.pop_front();
				n_seen <= n_seen + 1;
				if (sum_numerator !== e.sum_n || sum_denominator !== e.sum_d ||
				    max_numerator !== e.max_n || max_denominator !== e.max_d ||
				    status !== e.stat) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) begin
						$display("%0t: mismatch exp %0d/%0d max %0d/%0d st %0d",
							$realtime, e.sum_n, e.sum_d, e.max_n, e.max_d, e.stat);
						$display("%0t: mismatch got %0d/%0d max %0d/%0d st %0d",
							$realtime, sum_numerator, sum_denominator,
							max_numerator, max_denominator, status);
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the fraction sum and maximum block: directed
// corner fractions, then random lists with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import fsam_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] numerator;
	logic signed [31:0] denominator;
	logic               last_item;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] sum_numerator;
	logic        [62:0] sum_denominator;
	logic signed [31:0] max_numerator;
	logic        [30:0] max_denominator;
	logic        [1:0]  status;
	int                 fail_count;
	int                 pending;
	logic               hold_off;
	logic               feed_done;

	fraction_sum_and_max u_top (.*);

	fsam_checker u_checker (.*);

	// clock and reset
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// send one transaction after the given gap; valid stays high when no gap follows
	task automatic send(logic signed [31:0] n, logic signed [31:0] d, logic l, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		numerator <= n;
		denominator <= d;
		last_item <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $signed($urandom_range(0, 20)) - 10;
			2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// receiver: random wait per result transaction, longer while held off
	initial begin
		int rx_wait;
		out_stall = 1;
		hold_off = 0;
		@(posedge arst_n);
		forever begin
			rx_wait = $urandom_range(0, 17);
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			repeat (rx_wait) @(negedge clk);
			while (hold_off) @(negedge clk);
			out_stall <= 0;
			@(posedge clk);
			@(negedge clk);
			out_stall <= 1;
		end
	end

	// long receiver hold-off while the sender keeps going
	initial begin
		@(posedge arst_n);
		repeat (20000) @(posedge clk);
		hold_off = 1;
		repeat (6000) @(posedge clk);
		hold_off = 0;
	end

	// stimulus
	initial begin
		logic signed [31:0] corner [0:9];
		int gap;
		in_valid = 0;
		numerator = 0;
		denominator = 1;
		last_item = 0;
		feed_done = 0;
		corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1, 2, -2, 3, 32'sh7FFF_FFFE, -7};
		@(posedge arst_n);
		@(negedge clk);
		// directed: extremes, zero denominator, too-wide reduced values, ties
		send(32'sh8000_0000, 1, 1, 0);
		send(32'sh8000_0000, -1, 1, 0);
		send(32'sh8000_0000, 32'sh8000_0000, 1, 0);
		send(5, 0, 0, 0);
		send(1, 2, 1, 0);
		send(1, 3, 0, 0);
		send(2, 6, 0, 0);
		send(-1, -3, 1, 0);
		send(0, 32'sh8000_0000, 1, 0);
		send(1, 32'sh8000_0000, 1, 0);
		send(2, 32'sh8000_0000, 1, 0);
		send(32'sh7FFF_FFFF, 1, 0, 0);
		send(32'sh7FFF_FFFF, 1, 0, 0);
		send(32'sh7FFF_FFFF, 1, 1, 0);
		send(1, 32'sh7FFF_FFFF, 0, 0);
		send(1, 32'sh7FFF_FFFE, 0, 0);
		send(1, 32'sh7FFF_FFFD, 0, 0);
		send(7, 0, 1, 0);
		send(-3, 4, 0, 0);
		send(3, 4, 1, 0);
		// random lists
		for (int i = 0; i < 1080; i++) begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			if (i == 500) begin
				@(negedge clk);
				in_valid <= 0;
				while (pending != 0) @(negedge clk);
			end
			if ($urandom_range(0, 9) == 0)
				send(corner[$urandom_range(0, 9)], corner[$urandom_range(0, 9)],
					$urandom_range(0, 3) == 0, gap);
			else
				send(pick_value(), pick_value(), $urandom_range(0, 3) == 0, gap);
		end
		send(1, 1, 1, 0);
		@(negedge clk);
		in_valid <= 0;
		feed_done = 1;
	end

	// verdict
	initial begin
		@(posedge feed_done);
		while (pending != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// timeout
	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
